@@ rtl/core/gsfp_pkg.sv @@
// ----------------------------------------------------------------------------
// gsfp_pkg
// Shared constants and types for the gas sensor frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsfp_pkg;

	localparam int FRAME_LEN = 9;
	localparam int POS_W     = $clog2(FRAME_LEN);

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] CMD_BYTE   = 8'h86;

	localparam logic [POS_W-1:0] POS_START    = POS_W'(0);
	localparam logic [POS_W-1:0] POS_CMD      = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CONC_HI  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_CONC_LO  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(FRAME_LEN - 1);

	typedef struct packed {
		logic        hundredths;
		logic [7:0]  gas_type;
		logic [15:0] concentration;
	} result_t;

endpackage

@@ rtl/core/gsfp_framer.sv @@
// ----------------------------------------------------------------------------
// gsfp_framer
// Frame position tracking, byte capture and checksum check, one byte a cycle while step is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsfp_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          unit_scale_gas_code,
	output logic                res_valid,
	output gsfp_pkg::result_t   res
);

	logic [gsfp_pkg::POS_W-1:0] pos_q;
	logic [gsfp_pkg::POS_W-1:0] pos_d;
	logic [7:0]                 sum_q;
	logic [7:0]                 sum_d;
	logic [7:0]                 conc_hi_q;
	logic [7:0]                 conc_lo_q;
	logic [7:0]                 type_q;
	logic [7:0]                 expect_sum;

	assign expect_sum = (~sum_q) + 8'd1;

	always_comb begin
		pos_d     = pos_q;
		sum_d     = sum_q;
		res_valid = 1'b0;
		case (pos_q)
			gsfp_pkg::POS_START: begin
				if (rx_byte == gsfp_pkg::START_BYTE) begin
					pos_d = gsfp_pkg::POS_CMD;
					sum_d = 8'd0;
				end
			end
			gsfp_pkg::POS_CMD: begin
				if (rx_byte == gsfp_pkg::CMD_BYTE) begin
					pos_d = gsfp_pkg::POS_CONC_HI;
					sum_d = rx_byte;
				end else begin
					pos_d = gsfp_pkg::POS_START;
				end
			end
			gsfp_pkg::POS_CHECKSUM: begin
				pos_d     = gsfp_pkg::POS_START;
				res_valid = step && (rx_byte == expect_sum);
			end
			default: begin
				if (pos_q < gsfp_pkg::POS_CHECKSUM) begin
					pos_d = pos_q + gsfp_pkg::POS_W'(1);
					sum_d = sum_q + rx_byte;
				end else begin
					pos_d = gsfp_pkg::POS_START;
				end
			end
		endcase
	end

	assign res.concentration = {conc_hi_q, conc_lo_q};
	assign res.gas_type      = type_q;
	assign res.hundredths    = (type_q != unit_scale_gas_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= gsfp_pkg::POS_START;
			sum_q <= 8'd0;
		end else if (step) begin
			pos_q <= pos_d;
			sum_q <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (pos_q == gsfp_pkg::POS_CONC_HI) conc_hi_q <= rx_byte;
			if (pos_q == gsfp_pkg::POS_CONC_LO) conc_lo_q <= rx_byte;
			if (pos_q == gsfp_pkg::POS_TYPE)    type_q    <= rx_byte;
		end
	end

endmodule

@@ rtl/core/gsfp_out_buf.sv @@
// ----------------------------------------------------------------------------
// gsfp_out_buf
// Result register with a skid entry; ready toward the framer is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsfp_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gsfp_pkg::result_t in_res,
	output logic              out_valid,
	input  logic              out_ready,
	output gsfp_pkg::result_t out_res
);

	logic              main_v_q;
	logic              skid_v_q;
	gsfp_pkg::result_t main_q;
	gsfp_pkg::result_t skid_q;

	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (main_v_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) main_q <= skid_q;
		end else if (in_valid) begin
			if (main_v_q && !out_ready) skid_q <= in_res;
			else                        main_q <= in_res;
		end
	end

endmodule

@@ rtl/core/gas_sensor_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// gas_sensor_frame_parser_core
// Frames 9-byte checksummed gas sensor packets from a serial byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per item, one item per cycle. An accepted byte sits
// in an input register, is then framed and checked, and a frame with a good
// checksum yields one result item, registered in the result buffer when its
// checksum byte leaves the input register. Bad start, bad command byte or bad
// checksum drop back to the start silently. The input stalls only while the
// two-entry result buffer is full. hundredths is 0 when the gas type equals
// the configured code (whole units) and 1 otherwise (0.01 units). Write the
// code only while idle.
`timescale 1ns / 1ps

module gas_sensor_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,       // unit_scale_gas_code
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] concentration, [23:16] gas_type
	output logic        m_axis_tuser    // [0] hundredths
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [7:0]        gas_code_q;
	logic              buf_ready;
	logic              step;
	logic              res_valid;
	gsfp_pkg::result_t res;
	gsfp_pkg::result_t out_res;

	assign cfg_ready     = 1'b1;
	assign step          = valid_s1 && buf_ready;
	assign s_axis_tready = !valid_s1 || buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gas_code_q <= 8'd0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_valid) gas_code_q <= cfg_data;
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) byte_s1 <= s_axis_tdata;
	end

	gsfp_framer u_framer (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (step),
		.rx_byte             (byte_s1),
		.unit_scale_gas_code (gas_code_q),
		.res_valid           (res_valid),
		.res                 (res)
	);

	gsfp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (buf_ready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.gas_type, out_res.concentration};
	assign m_axis_tuser = out_res.hundredths;

endmodule

@@ tb/sv/gsfp_checker.sv @@
// ----------------------------------------------------------------------------
// gsfp_checker
// Watches the config, byte and result channels of the frame parser, tracks
// framing state and checksum, and checks each result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsfp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	output int          fail_count,
	output int          pending
);

	logic [gsfp_pkg::POS_W-1:0] frame_pos;
	logic [7:0]                 byte_sum;
	logic [7:0]                 conc_hi;
	logic [7:0]                 conc_lo;
	logic [7:0]                 type_byte;
	logic [7:0]                 unit_code;
	gsfp_pkg::result_t          readings_q[$];

	function automatic void track_frame_byte(input logic [7:0] b);
		gsfp_pkg::result_t r;
		case (frame_pos)
			gsfp_pkg::POS_START: begin
				if (b == gsfp_pkg::START_BYTE) begin
					byte_sum  = 8'd0;
					frame_pos = gsfp_pkg::POS_CMD;
				end
			end
			gsfp_pkg::POS_CMD: begin
				if (b == gsfp_pkg::CMD_BYTE) begin
					byte_sum  = b;
					frame_pos = gsfp_pkg::POS_CONC_HI;
				end else begin
					frame_pos = gsfp_pkg::POS_START;
				end
			end
			gsfp_pkg::POS_CHECKSUM: begin
				frame_pos = gsfp_pkg::POS_START;
				if (b == 8'(8'hFF - byte_sum + 8'd1)) begin
					r.concentration = {conc_hi, conc_lo};
					r.gas_type      = type_byte;
					r.hundredths    = (type_byte != unit_code);
					readings_q.push_back(r);
				end
			end
			default: begin
				if (frame_pos < gsfp_pkg::POS_CHECKSUM) begin
					if (frame_pos == gsfp_pkg::POS_CONC_HI)
						conc_hi = b;
					else if (frame_pos == gsfp_pkg::POS_CONC_LO)
						conc_lo = b;
					else if (frame_pos == gsfp_pkg::POS_TYPE)
						type_byte = b;
					byte_sum  = byte_sum + b;
					frame_pos = frame_pos + 1'b1;
				end else begin
					frame_pos = gsfp_pkg::POS_START;
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int                errs;
		gsfp_pkg::result_t want;
		errs = 0;
		if (!arst_n) begin
			frame_pos = gsfp_pkg::POS_START;
			byte_sum  = 8'd0;
			conc_hi   = 8'd0;
			conc_lo   = 8'd0;
			type_byte = 8'd0;
			unit_code = 8'd0;
			readings_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				unit_code = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (readings_q.size() == 0) begin
					$error("unexpected result item: tdata=%h tuser=%b",
						m_axis_tdata, m_axis_tuser);
					errs++;
				end else begin
					want = readings_q.pop_front();
					if (m_axis_tdata[15:0] !== want.concentration) begin
						$error("concentration: expected %h, got %h",
							want.concentration, m_axis_tdata[15:0]);
						errs++;
					end
					if (m_axis_tdata[23:16] !== want.gas_type) begin
						$error("gas_type: expected %h, got %h",
							want.gas_type, m_axis_tdata[23:16]);
						errs++;
					end
					if (m_axis_tuser !== want.hundredths) begin
						$error("hundredths: expected %b, got %b",
							want.hundredths, m_axis_tuser);
						errs++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				track_frame_byte(s_axis_tdata);
			fail_count <= fail_count + errs;
			pending    <= readings_q.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the gas sensor frame parser: directed frames for
// the header, checksum and scale corner cases, then phases of random frames,
// broken frames and noise under several gas codes, with random idling on
// both sides in all but one phase. A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;

	int          fail_count;
	int          pending;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	logic [7:0]  tx_q[$];

	gas_sensor_frame_parser_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	gsfp_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		m_axis_tready <= !rx_idle_en || ($urandom_range(0, 99) >= 24);
	end

	task automatic send_byte(input logic [7:0] b);
		while (tx_idle_en && $urandom_range(0, 99) < 24) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_queued();
		while (tx_q.size() > 0)
			send_byte(tx_q.pop_front());
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// hold off until all readings are out and the pipeline has drained
	task automatic wait_readings_done();
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_gas_code(input logic [7:0] code);
		cfg_valid <= 1'b1;
		cfg_data  <= code;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_frame(input logic [15:0] conc, input logic [7:0] gas,
			input logic [7:0] t5, input logic [7:0] t6, input logic [7:0] t7,
			input bit good_sum);
		logic [7:0] sum;
		logic [7:0] cks;
		sum = gsfp_pkg::CMD_BYTE + conc[15:8] + conc[7:0] + gas + t5 + t6 + t7;
		cks = 8'hFF - sum + 8'd1;
		if (!good_sum)
			cks = cks ^ 8'($urandom_range(1, 255));
		tx_q.push_back(gsfp_pkg::START_BYTE);
		tx_q.push_back(gsfp_pkg::CMD_BYTE);
		tx_q.push_back(conc[15:8]);
		tx_q.push_back(conc[7:0]);
		tx_q.push_back(gas);
		tx_q.push_back(t5);
		tx_q.push_back(t6);
		tx_q.push_back(t7);
		tx_q.push_back(cks);
	endtask

	task automatic queue_random_chunk(input logic [7:0] code);
		int          sel;
		int          n;
		logic [15:0] conc;
		logic [7:0]  gas;
		sel  = $urandom_range(0, 99);
		conc = 16'($urandom);
		case ($urandom_range(0, 9))
			0: conc = 16'h0000;
			1: conc = 16'hFFFF;
			default: ;
		endcase
		gas = $urandom_range(0, 1) ? code : 8'($urandom);
		if (sel < 65) begin
			queue_frame(conc, gas, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
		end else if (sel < 75) begin
			queue_frame(conc, gas, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
		end else if (sel < 80) begin
			// bad command byte, sometimes another start byte
			tx_q.push_back(gsfp_pkg::START_BYTE);
			tx_q.push_back($urandom_range(0, 1) ? gsfp_pkg::START_BYTE :
				8'($urandom_range(0, gsfp_pkg::CMD_BYTE - 8'd1)));
		end else if (sel < 88) begin
			// truncated frame
			tx_q.push_back(gsfp_pkg::START_BYTE);
			tx_q.push_back(gsfp_pkg::CMD_BYTE);
			n = $urandom_range(1, 6);
			repeat (n) tx_q.push_back(8'($urandom));
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) tx_q.push_back(8'($urandom));
		end
	endtask

	initial begin
		logic [7:0] phase_code[4];
		phase_code[0] = 8'h00;
		phase_code[1] = 8'($urandom_range(1, 254));
		phase_code[2] = 8'hFF;
		phase_code[3] = 8'($urandom);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: code FF so a type of FF reads in whole units
		write_gas_code(8'hFF);
		tx_q.push_back(8'h00);
		tx_q.push_back(gsfp_pkg::START_BYTE);
		tx_q.push_back(gsfp_pkg::START_BYTE);
		// full-scale reading whose byte sum wraps to zero
		queue_frame(16'hFFFF, 8'hFF, 8'h7D, 8'h00, 8'h00, 1'b1);
		queue_frame(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_queued();
		wait_readings_done();

		for (int p = 0; p < 4; p++) begin
			tx_idle_en = (p != 2);
			rx_idle_en = (p != 2);
			write_gas_code(phase_code[p]);
			while (tx_q.size() < 375)
				queue_random_chunk(phase_code[p]);
			send_queued();
			wait_readings_done();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
